FILE: hdl/sdsg_pkg.sv
package sdsg_pkg;

  // Defaults for the top-level parameters
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int HOLD_MS_DEF      = 250;
  localparam int CLICK_EVERY_DEF  = 4;

  // Fixed field widths
  localparam int STEP_W    = 16;
  localparam int COUNT_W   = 16;
  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_ZOOM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_STEP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_STEP = 2'd3;

  // Configuration reset values
  localparam logic [CFG_DAT_W-1:0] DEAD_BAND_RST  = 16'd8;
  localparam logic [STEP_W-1:0]    ZOOM_STEP_RST  = 16'd64;
  localparam logic [STEP_W-1:0]    WHEEL_STEP_RST = 16'd32;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hdl/sdsg_div.sv
// Restoring divider, one quotient bit per cycle.
module sdsg_div #(
  parameter int DVD_W = 17
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DVD_W-1:0]              dividend,
  input  logic [sdsg_pkg::STEP_W-1:0]   divisor,
  output logic [DVD_W-1:0]              quotient,
  output logic [sdsg_pkg::STEP_W-1:0]   remainder,
  output sdsg_pkg::div_stat_t           stat
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]              q_r;
  logic [sdsg_pkg::STEP_W-1:0]   rem_r;
  logic [sdsg_pkg::STEP_W-1:0]   d_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          done_r;

  logic [sdsg_pkg::STEP_W:0]     shifted;
  logic [sdsg_pkg::STEP_W:0]     diff;
  logic                          fits;

  assign shifted = {rem_r, q_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, d_r};
  assign fits    = (shifted >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r   <= dividend;
        rem_r <= '0;
        d_r   <= divisor;
        cnt_r <= CNT_W'(DVD_W);
      end else if (cnt_r != '0) begin
        rem_r <= fits ? diff[sdsg_pkg::STEP_W-1:0] : shifted[sdsg_pkg::STEP_W-1:0];
        q_r   <= {q_r[DVD_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient  = q_r;
  assign remainder = rem_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

FILE: hdl/slider_delta_step_generator_core.sv
// Channel  Dir  Ports              Contents
// in_      in   tvalid/tready      tdata: sample, time_ms; tuser: touch_held
// out_     out  tvalid/tready      tdata: step_count, haptic_click, leds; tuser: direction, kind
// cfg_     in   we/addr/wdata      write-only register port, no handshake
//
// A dividing item passes through the idle (accept), evaluate, divide and emit states;
// items that cause no division (touch held, first sample, inside dead band) go from
// evaluate straight to emit.
// in_tready is high only while the sequencer is idle; the output register lets the
// next item start while a result waits, and emit stalls until out_ is free.
// rst_n is synchronous; it clears control state and config registers to defaults.
module slider_delta_step_generator_core #(
  parameter int SAMPLE_WIDTH = sdsg_pkg::SAMPLE_WIDTH_DEF,
  parameter int HOLD_MS      = sdsg_pkg::HOLD_MS_DEF,
  parameter int CLICK_EVERY  = sdsg_pkg::CLICK_EVERY_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // [SAMPLE_WIDTH-1:0] sample, then time_ms (32), zero pad to bytes
  input  logic [((SAMPLE_WIDTH+sdsg_pkg::TIME_W+7)/8)*8-1:0] in_tdata,
  // [0] touch_held
  input  logic                                        in_tuser,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // [15:0] step_count, [16] haptic_click, [17] led_red_on, [18] led_green_on, pad
  output logic [23:0]                                 out_tdata,
  // [0] step_negative, [1] steps_are_zoom
  output logic [1:0]                                  out_tuser,
  input  logic                                        cfg_we,
  input  logic [sdsg_pkg::CFG_IDX_W-1:0]              cfg_addr,
  input  logic [sdsg_pkg::CFG_DAT_W-1:0]              cfg_wdata
);

  localparam int CMP_W  = (SAMPLE_WIDTH > sdsg_pkg::STEP_W) ? SAMPLE_WIDTH : sdsg_pkg::STEP_W;
  localparam int AMAG_W = CMP_W + 1;
  localparam int ACC_W  = AMAG_W + 1;
  localparam int CLK_W  = $clog2(CLICK_EVERY + 1);
  localparam int TW     = sdsg_pkg::TIME_W;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DIV, S_EMIT} state_t;

  state_t state_r;

  // config
  logic                          mode_zoom_r;
  logic [sdsg_pkg::CFG_DAT_W-1:0] dead_band_r;
  logic [sdsg_pkg::STEP_W-1:0]   zoom_step_r;
  logic [sdsg_pkg::STEP_W-1:0]   wheel_step_r;

  // persistent state
  logic                          have_prev_r;
  logic [SAMPLE_WIDTH-1:0]       prev_sample_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic [CLK_W-1:0]              click_cnt_r;
  logic                          ind_red_r;
  logic [TW-1:0]                 deadline_r;
  logic                          red_r;
  logic                          green_r;

  // current item
  logic [SAMPLE_WIDTH-1:0]       smp_r;
  logic                          touch_r;
  logic [TW-1:0]                 now_r;
  logic                          moved_r;
  logic                          neg_r;
  logic                          zoom_r;

  // result register
  logic                          out_valid_r;
  logic [sdsg_pkg::COUNT_W-1:0]  out_count_r;
  logic                          out_neg_r;
  logic                          out_zoom_r;
  logic                          out_click_r;
  logic                          out_red_r;
  logic                          out_green_r;

  // evaluate-cycle datapath
  logic signed [SAMPLE_WIDTH:0]  change;
  logic [SAMPLE_WIDTH-1:0]       mag;
  logic                          past_band;
  logic signed [ACC_W-1:0]       sum;
  logic                          sum_neg;
  logic [AMAG_W-1:0]             amag;
  logic [sdsg_pkg::STEP_W-1:0]   step_sel;
  logic [sdsg_pkg::STEP_W-1:0]   step_div;
  logic                          div_start;

  // divider
  logic [AMAG_W-1:0]             div_q;
  logic [sdsg_pkg::STEP_W-1:0]   div_rem;
  sdsg_pkg::div_stat_t           div_stat;

  // emit-cycle datapath
  logic                          stepped;
  logic [sdsg_pkg::COUNT_W-1:0]  count_sat;
  logic signed [ACC_W-1:0]       rem_ext;
  logic [CLK_W-1:0]              click_inc;
  logic                          click_fire;
  logic [TW-1:0]                 hold_end;
  logic                          expire;
  logic                          emit_ok;

  assign change    = $signed({1'b0, smp_r}) - $signed({1'b0, prev_sample_r});
  assign mag       = change[SAMPLE_WIDTH] ? SAMPLE_WIDTH'(-change) : SAMPLE_WIDTH'(change);
  assign past_band = (CMP_W'(mag) > CMP_W'(dead_band_r));
  assign sum       = acc_r + ACC_W'(change);
  assign sum_neg   = sum[ACC_W-1];
  assign amag      = sum_neg ? AMAG_W'(-sum) : AMAG_W'(sum);
  assign step_sel  = mode_zoom_r ? zoom_step_r : wheel_step_r;
  // a step size of zero behaves as one
  assign step_div  = (step_sel == '0) ? sdsg_pkg::STEP_W'(1) : step_sel;
  assign expire    = (deadline_r != '0) && (now_r > deadline_r);
  assign div_start = (state_r == S_EVAL) && !touch_r && have_prev_r && past_band;

  sdsg_div #(
    .DVD_W(AMAG_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (amag),
    .divisor  (step_div),
    .quotient (div_q),
    .remainder(div_rem),
    .stat     (div_stat)
  );

  assign stepped    = moved_r && (div_q != '0);
  assign count_sat  = (|div_q[AMAG_W-1:sdsg_pkg::COUNT_W]) ? '1 : div_q[sdsg_pkg::COUNT_W-1:0];
  assign rem_ext    = ACC_W'(div_rem);
  assign click_inc  = click_cnt_r + 1'b1;
  assign click_fire = (click_inc == CLK_W'(CLICK_EVERY));
  assign hold_end   = now_r + TW'(HOLD_MS);
  assign emit_ok    = !out_valid_r || out_tready;

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_zoom_r  <= 1'b0;
      dead_band_r  <= sdsg_pkg::DEAD_BAND_RST;
      zoom_step_r  <= sdsg_pkg::ZOOM_STEP_RST;
      wheel_step_r <= sdsg_pkg::WHEEL_STEP_RST;
      have_prev_r  <= 1'b0;
      prev_sample_r <= '0;
      acc_r        <= '0;
      click_cnt_r  <= '0;
      ind_red_r    <= 1'b0;
      deadline_r   <= '0;
      red_r        <= 1'b0;
      green_r      <= 1'b0;
      moved_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          sdsg_pkg::CFG_MODE_ZOOM:  mode_zoom_r  <= cfg_wdata[0];
          sdsg_pkg::CFG_DEAD_BAND:  dead_band_r  <= cfg_wdata;
          sdsg_pkg::CFG_ZOOM_STEP:  zoom_step_r  <= cfg_wdata;
          sdsg_pkg::CFG_WHEEL_STEP: wheel_step_r <= cfg_wdata;
          default: ;
        endcase
      end

      // the emit state sets the valid itself when the register frees up
      if (out_valid_r && out_tready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            smp_r   <= in_tdata[SAMPLE_WIDTH-1:0];
            now_r   <= in_tdata[SAMPLE_WIDTH +: TW];
            touch_r <= in_tuser;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (expire) begin
            deadline_r <= '0;
            red_r      <= 1'b0;
            green_r    <= 1'b0;
          end
          moved_r <= div_start;
          neg_r   <= sum_neg;
          zoom_r  <= mode_zoom_r;
          if (!touch_r && !have_prev_r) begin
            have_prev_r   <= 1'b1;
            prev_sample_r <= smp_r;
          end
          if (div_start) begin
            prev_sample_r <= smp_r;
            state_r       <= S_DIV;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_valid_r <= 1'b1;
            out_count_r <= stepped ? count_sat : '0;
            out_neg_r   <= stepped && neg_r;
            out_zoom_r  <= stepped && zoom_r;
            out_click_r <= stepped && click_fire;
            if (moved_r) begin
              acc_r <= neg_r ? -rem_ext : rem_ext;
            end
            if (stepped) begin
              click_cnt_r <= click_fire ? '0 : click_inc;
              ind_red_r   <= zoom_r;
              deadline_r  <= hold_end;
              red_r       <= zoom_r;
              green_r     <= !zoom_r;
              out_red_r   <= zoom_r;
              out_green_r <= !zoom_r;
            end else begin
              // a move with no whole step restarts the hold time when the last step used the same mode
              if (moved_r && (ind_red_r == zoom_r)) begin
                deadline_r <= hold_end;
              end
              out_red_r   <= red_r;
              out_green_r <= green_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_green_r, out_red_r, out_click_r, out_count_r};
  assign out_tuser  = {out_zoom_r, out_neg_r};

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> div_stat.busy || div_stat.done)
    else $error("waiting on an idle divider");

  a_eval_next: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |=> state_r == S_DIV || state_r == S_EMIT)
    else $error("evaluate went to an unexpected state");

  a_click_range: assert property (@(posedge clk) disable iff (!rst_n)
    click_cnt_r < CLK_W'(CLICK_EVERY))
    else $error("click counter out of range");

  a_lamps_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(red_r && green_r))
    else $error("both lamps lit");
`endif

endmodule

FILE: test/slider_delta_step_generator_core_tb.sv
`timescale 1ns / 100ps

module slider_delta_step_generator_core_tb;

  localparam int SAMPLE_W    = sdsg_pkg::SAMPLE_WIDTH_DEF;
  localparam int HOLD_MS     = sdsg_pkg::HOLD_MS_DEF;
  localparam int CLICK_EVERY = sdsg_pkg::CLICK_EVERY_DEF;
  localparam int IN_W        = ((SAMPLE_W + sdsg_pkg::TIME_W + 7) / 8) * 8;
  localparam int DRAIN_CYC   = 40;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic [sdsg_pkg::COUNT_W-1:0] count;
    logic               negative;
    logic               zoom;
    logic               click;
    logic               red;
    logic               green;
  } step_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [sdsg_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [15:0]          value;   // sample, or register data
    logic                 touch;
    logic [31:0]          now;
    bit                   typed;
    step_result_t         res;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;   // [15:0] sample, [47:16] time_ms
  logic                 in_tuser = 1'b0; // [0] touch_held
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;       // [15:0] step_count, [16] haptic_click,
                                         // [17] led_red_on, [18] led_green_on
  logic [1:0]           out_tuser;       // [0] step_negative, [1] steps_are_zoom
  logic                 cfg_we = 1'b0;
  logic [sdsg_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [sdsg_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;

  // register copies
  logic        zoom_mode_cfg = 1'b0;
  int          dead_band_cfg = int'(sdsg_pkg::DEAD_BAND_RST);
  int          zoom_step_cfg = int'(sdsg_pkg::ZOOM_STEP_RST);
  int          wheel_step_cfg = int'(sdsg_pkg::WHEEL_STEP_RST);

  // slider state
  logic        prev_valid = 1'b0;
  logic [15:0] last_sample = '0;
  int          step_acc = 0;
  int          click_cnt = 0;
  logic        lit_red = 1'b0;
  logic [31:0] lamp_deadline = '0;
  logic        red_on = 1'b0;
  logic        green_on = 1'b0;

  step_result_t pending_steps[$];
  plan_row_t    step_plan[$];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           errors = 0;
  int           items_sent = 0;
  int           results_checked = 0;
  int           cfg_writes = 0;

  slider_delta_step_generator_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic step_result_t predict_steps(input logic [15:0] smp, input logic hold,
                                                 input logic [31:0] now);
    step_result_t r;
    int change, mag, step_sz, amag, cnt;
    logic neg;
    r = '0;
    if (lamp_deadline != 0 && now > lamp_deadline) begin
      lamp_deadline = '0;
      red_on = 1'b0;
      green_on = 1'b0;
    end
    if (!hold) begin
      if (!prev_valid) begin
        prev_valid = 1'b1;
        last_sample = smp;
      end else begin
        change = $signed({16'b0, smp}) - $signed({16'b0, last_sample});
        mag = change < 0 ? -change : change;
        if (mag > dead_band_cfg) begin
          step_sz = zoom_mode_cfg ? zoom_step_cfg : wheel_step_cfg;
          if (step_sz == 0) step_sz = 1;
          last_sample = smp;
          step_acc += change;
          neg = step_acc < 0;
          amag = neg ? -step_acc : step_acc;
          cnt = amag / step_sz;
          amag = amag % step_sz;
          step_acc = neg ? -amag : amag;
          if (cnt > 0) begin
            r.negative = neg;
            r.zoom = zoom_mode_cfg;
            click_cnt++;
            if (click_cnt >= CLICK_EVERY) begin
              r.click = 1'b1;
              click_cnt = 0;
            end
            lit_red = zoom_mode_cfg;
            lamp_deadline = now + HOLD_MS;
            red_on = zoom_mode_cfg;
            green_on = !zoom_mode_cfg;
          end else if (lit_red == zoom_mode_cfg) begin
            // same color still selected: hold time restarts even with lamps off
            lamp_deadline = now + HOLD_MS;
          end
          r.count = cnt > 65535 ? 16'hFFFF : cnt[15:0];
        end
      end
    end
    r.red = red_on;
    r.green = green_on;
    return r;
  endfunction

  function automatic step_result_t mk_res(input int count, input bit neg, input bit zoom,
                                          input bit click, input bit red, input bit green);
    step_result_t r;
    r.count = count[15:0];
    r.negative = neg;
    r.zoom = zoom;
    r.click = click;
    r.red = red;
    r.green = green;
    return r;
  endfunction

  function automatic void add_item(input logic [15:0] smp, input logic hold,
                                   input logic [31:0] now, input bit typed = 0,
                                   input step_result_t res = '0);
    plan_row_t row;
    row.kind = ROW_ITEM;
    row.reg_idx = '0;
    row.value = smp;
    row.touch = hold;
    row.now = now;
    row.typed = typed;
    row.res = res;
    step_plan.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [sdsg_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [15:0] val);
    plan_row_t row;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.value = val;
    row.touch = 1'b0;
    row.now = '0;
    row.typed = 0;
    row.res = '0;
    step_plan.push_back(row);
  endfunction

  function automatic logic [15:0] pick_step_size();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1;
      3: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(2, 200));
    endcase
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // result side
  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    step_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_steps.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, expected none, actual %h/%h",
                 $time, out_tdata, out_tuser);
      end else begin
        want = pending_steps.pop_front();
        results_checked++;
        check_field("step_count", want.count, out_tdata[15:0]);
        check_field("haptic_click", want.click, out_tdata[16]);
        check_field("led_red_on", want.red, out_tdata[17]);
        check_field("led_green_on", want.green, out_tdata[18]);
        check_field("step_negative", want.negative, out_tuser[0]);
        check_field("steps_are_zoom", want.zoom, out_tuser[1]);
      end
    end
  end

  // called at a falling edge; leaves in_tvalid high after the transfer
  task automatic send_item(input logic [15:0] smp, input logic hold, input logic [31:0] now,
                           input bit typed, input step_result_t typed_res);
    step_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {now, smp};
    in_tuser <= hold;
    do @(posedge clk); while (!in_tready);
    r = predict_steps(smp, hold, now);
    pending_steps.push_back(typed ? typed_res : r);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    wait (pending_steps.size() == 0);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  // cfg_we stays high across back-to-back writes; release_cfg drops it
  task automatic write_reg(input logic [sdsg_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    cfg_writes++;
    case (idx)
      sdsg_pkg::CFG_MODE_ZOOM:  zoom_mode_cfg = val[0];
      sdsg_pkg::CFG_DEAD_BAND:  dead_band_cfg = int'(val);
      sdsg_pkg::CFG_ZOOM_STEP:  zoom_step_cfg = int'(val);
      sdsg_pkg::CFG_WHEEL_STEP: wheel_step_cfg = int'(val);
      default: ;
    endcase
  endtask

  task automatic release_cfg();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int send_pct[4];
    int stall_pct[4];
    bit in_cfg;
    int done_items, r, nxt, span;
    logic [15:0] smp_now;
    logic [31:0] t_now;
    logic hold;

    send_pct = '{0, 53, 0, 18};
    stall_pct = '{0, 0, 53, 18};

    // directed rows, registers at reset values first
    add_item(16'd100, 1'b0, 32'd10, 1, mk_res(0, 0, 0, 0, 0, 0));   // first sample
    add_item(16'd0, 1'b1, 32'd11, 1, mk_res(0, 0, 0, 0, 0, 0));     // touch held
    add_item(16'd105, 1'b0, 32'd12, 1, mk_res(0, 0, 0, 0, 0, 0));   // inside dead band
    add_item(16'd108, 1'b0, 32'd13, 1, mk_res(0, 0, 0, 0, 0, 0));   // on dead band edge
    add_item(16'd109, 1'b0, 32'd14);                                // change, no step
    add_item(16'd173, 1'b0, 32'd15, 1, mk_res(2, 0, 0, 0, 0, 1));
    add_item(16'd0, 1'b0, 32'd16, 1, mk_res(5, 1, 0, 0, 0, 1));
    add_item(16'hFFFF, 1'b0, 32'd17);
    add_item(16'd0, 1'b1, 32'd300, 1, mk_res(0, 0, 0, 0, 0, 0));    // lamps expire
    add_item(16'd0, 1'b0, 32'd301);                                 // fourth click
    add_cfg(sdsg_pkg::CFG_WHEEL_STEP, 16'd0);
    add_cfg(sdsg_pkg::CFG_DEAD_BAND, 16'd0);
    add_item(16'hFFFF, 1'b0, 32'd302);
    add_item(16'hFFFE, 1'b0, 32'd303);
    add_cfg(sdsg_pkg::CFG_MODE_ZOOM, 16'd1);
    add_cfg(sdsg_pkg::CFG_ZOOM_STEP, 16'd1);
    add_item(16'd0, 1'b0, 32'hFFFF_FF06);                           // deadline wraps to 0
    add_item(16'hFFFF, 1'b0, 32'hFFFF_FFFF);
    add_item(16'hFFFF, 1'b1, 32'd0);
    add_cfg(sdsg_pkg::CFG_ZOOM_STEP, 16'hFFFF);
    add_cfg(sdsg_pkg::CFG_DEAD_BAND, 16'hFFFF);
    add_item(16'd0, 1'b0, 32'd5, 1, mk_res(0, 0, 0, 0, 1, 0));
    add_cfg(sdsg_pkg::CFG_DEAD_BAND, 16'd8);
    add_item(16'd100, 1'b0, 32'd6);
    add_item(16'hFFFF, 1'b0, 32'd300);
    add_cfg(sdsg_pkg::CFG_MODE_ZOOM, 16'd0);
    add_cfg(sdsg_pkg::CFG_WHEEL_STEP, 16'hFFFF);
    add_item(16'd0, 1'b0, 32'd301);
    add_cfg(sdsg_pkg::CFG_WHEEL_STEP, 16'd32);
    add_cfg(sdsg_pkg::CFG_ZOOM_STEP, 16'd64);
    add_item(16'hAAAA, 1'b0, 32'h5555_5555);
    add_item(16'h5555, 1'b0, 32'hAAAA_AAAA);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    in_cfg = 0;
    foreach (step_plan[i]) begin
      if (step_plan[i].kind == ROW_CFG) begin
        if (!in_cfg) begin
          settle();
          in_cfg = 1;
        end
        write_reg(step_plan[i].reg_idx, step_plan[i].value);
      end else begin
        if (in_cfg) begin
          release_cfg();
          in_cfg = 0;
        end
        send_item(step_plan[i].value, step_plan[i].touch, step_plan[i].now,
                  step_plan[i].typed, step_plan[i].res);
      end
    end

    smp_now = 16'h5555;
    t_now = 32'd1000;
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      send_idle_pct = send_pct[ph];
      recv_stall_pct = stall_pct[ph];
      write_reg(sdsg_pkg::CFG_MODE_ZOOM, 16'($urandom_range(1)));
      case ($urandom_range(5))
        0: write_reg(sdsg_pkg::CFG_DEAD_BAND, 16'd0);
        1: write_reg(sdsg_pkg::CFG_DEAD_BAND, 16'($urandom_range(2000)));
        default: write_reg(sdsg_pkg::CFG_DEAD_BAND, 16'($urandom_range(40)));
      endcase
      write_reg(sdsg_pkg::CFG_ZOOM_STEP, pick_step_size());
      write_reg(sdsg_pkg::CFG_WHEEL_STEP, pick_step_size());
      release_cfg();
      if (ph == 3) t_now = 32'hFFFF_F000;   // run across the time wrap

      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 5) smp_now = 16'($urandom_range(65535));
        else if (r < 8) smp_now = r[0] ? 16'hFFFF : 16'h0000;
        else begin
          span = ($urandom_range(3) == 0) ? 4000 : 300;
          nxt = int'(smp_now) + int'($urandom_range(2 * span)) - span;
          if (nxt < 0) nxt = 0;
          if (nxt > 65535) nxt = 65535;
          smp_now = nxt[15:0];
        end
        r = $urandom_range(99);
        if (r < 3) t_now = $urandom;
        else if (r < 5) t_now = 32'hFFFF_FF00 + $urandom_range(255);
        else if (r < 15) t_now = t_now + $urandom_range(200, 400);
        else t_now = t_now + $urandom_range(0, 120);
        hold = ($urandom_range(9) == 0);
        send_item(smp_now, hold, t_now, 0, '0);
        done_items++;
      end
    end

    settle();
    $display("Covered %0d slider samples (%0d results checked) and %0d register writes,",
             items_sent, results_checked, cfg_writes);
    $display("over four handshake pacing phases; %0d field mismatches.", errors);
    if (errors == 0) begin
      $display("PASS slider_delta_step_generator_core");
    end else begin
      $display("FAIL slider_delta_step_generator_core");
    end
    $finish;
  end

  initial begin
    #(64'd20_000_000);
    $display("Timeout with %0d results still outstanding", pending_steps.size());
    $display("FAIL slider_delta_step_generator_core");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/sdsg_pkg.sv
hdl/sdsg_div.sv
hdl/slider_delta_step_generator_core.sv
test/slider_delta_step_generator_core_tb.sv
